// ===== src/time_partition_scheduler_defines.svh =====
// ---------------------------------------------------------------------------
// Time partition scheduler assertion macros
// Checks that can be compiled out by defining NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef TIME_PARTITION_SCHEDULER_DEFINES_SVH
`define TIME_PARTITION_SCHEDULER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that is switched off while reset is asserted.
`define TPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds during reset.
`define TPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/tps_pkg.sv =====
// ---------------------------------------------------------------------------
// Time partition scheduler package
// Sizes, codes and register indexes for the partition scheduler.
// ---------------------------------------------------------------------------
package tps_pkg;

    localparam int MAX_SLICES  = 16;
    localparam int SLICE_IDX_W = $clog2(MAX_SLICES);
    localparam int NSL_W       = 5;    // num_slices register and slice position
    localparam int CHAN_W      = 6;
    localparam int TIME_W      = 64;
    localparam int LOAD_IDX_W  = 4;
    localparam int NOTIFY_W    = 4;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int IN_DATA_W   = 144;  // 138 bits of fields, padded to bytes
    localparam int OUT_DATA_W  = 72;

    localparam logic [CHAN_W-1:0] TIMER_CH_RESET    = 6'd63;
    localparam logic [NSL_W-1:0]  NUM_SLICES_RESET  = 5'd1;
    localparam logic [TIME_W-1:0] START_DELAY_RESET = 64'd1000000000;

    typedef enum logic
    {
        OP_NOTIFY = 1'b0,
        OP_LOAD   = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_HANDLED = 2'd0,
        ST_ALREADY = 2'd1,
        ST_UNKNOWN = 2'd2,
        ST_LOADED  = 2'd3
    } status_t;

    typedef enum logic [CFG_ADDR_W-1:0]
    {
        CFG_TIMER_CH    = 2'd0,
        CFG_NUM_SLICES  = 2'd1,
        CFG_HYPERPERIOD = 2'd2,
        CFG_START_DELAY = 2'd3
    } cfg_idx_t;

endpackage

// ===== src/time_partition_scheduler.sv =====
// ---------------------------------------------------------------------------
// Time partition scheduler
// Fixed time-slice schedule over a table of slice lengths; tracks partition
// readiness and turns timer notifications into slice starts and timeouts.
//
//  Channel   Dir  Signals                              Contents
//  s_*       in   s_tvalid s_tready s_tdata s_tuser    load or notification
//  m_*       out  m_tvalid m_tready m_tdata            notify/timeout result
//  cfg_*     in   cfg_we cfg_addr cfg_wdata            register writes
//
//  One word accepted per cycle while s_tready is high; its result is
//  registered in stage 1 (control update and table read), then in the
//  output register, and is offered from there.
//  Slice table: 16 x 64 synchronous memory, read per word, written by loads.
//  Table contents are undefined after reset until loaded; no clearing pass.
//  A stall on m_tready holds the output and the stage behind it; s_tready
//  drops only when both are full.
// ---------------------------------------------------------------------------
`include "time_partition_scheduler_defines.svh"

module time_partition_scheduler
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // channel[5:0], now_ns[69:6], slice_index[73:70], slice_ns[137:74], zero pad
    input  logic [tps_pkg::IN_DATA_W-1:0]    s_tdata,
    // opcode[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // notify_valid[0], notify_slice[4:1], timeout_valid[5], timeout_ns[69:6],
    // status[71:70]
    output logic [tps_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [tps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    // configuration
    logic [tps_pkg::CHAN_W-1:0]     timer_ch_reg;
    logic [tps_pkg::NSL_W-1:0]      num_slices_reg;
    logic [tps_pkg::TIME_W-1:0]     hyper_reg;
    logic [tps_pkg::TIME_W-1:0]     start_delay_reg;

    // scheduler state
    logic [tps_pkg::NSL_W-1:0]      pos_reg, pos_next;
    logic                           running_reg, running_next;
    logic [tps_pkg::MAX_SLICES-1:0] mask_reg, mask_next;
    logic [tps_pkg::TIME_W-1:0]     cycle_end_reg, cycle_end_next;

    // slice length memory
    logic [tps_pkg::TIME_W-1:0]     slice_mem [tps_pkg::MAX_SLICES];
    logic [tps_pkg::TIME_W-1:0]     rd_data_reg;
    logic [tps_pkg::SLICE_IDX_W-1:0] rd_addr;
    logic [tps_pkg::SLICE_IDX_W-1:0] wr_addr;
    logic                           mem_we;

    // stage 1: result waiting for table data
    logic                           s1_valid_reg;
    logic                           s1_nv_reg, s1_nv_next;
    logic [tps_pkg::NOTIFY_W-1:0]   s1_ns_reg, s1_ns_next;
    logic                           s1_tv_reg, s1_tv_next;
    logic [tps_pkg::TIME_W-1:0]     s1_tns_reg, s1_tns_next;
    logic                           s1_use_mem_reg, s1_use_mem_next;
    tps_pkg::status_t               s1_st_reg, s1_st_next;

    // output stage
    logic                           out_valid_reg;
    logic [tps_pkg::OUT_DATA_W-1:0] out_data_reg;

    // input fields
    tps_pkg::opcode_t               in_op;
    logic [tps_pkg::CHAN_W-1:0]     in_ch;
    logic [tps_pkg::TIME_W-1:0]     in_now;
    logic [tps_pkg::LOAD_IDX_W-1:0] in_idx;
    logic [tps_pkg::TIME_W-1:0]     in_len;

    logic                           accept;
    logic                           out_free;
    logic                           s1_free;
    logic [tps_pkg::NSL_W-1:0]      n_eff;
    logic [tps_pkg::NSL_W-1:0]      pos_inc;
    logic [tps_pkg::NSL_W-1:0]      p_sel;
    logic [tps_pkg::MAX_SLICES:0]   full_ext;
    logic [tps_pkg::MAX_SLICES-1:0] full_mask;
    logic [tps_pkg::MAX_SLICES-1:0] ch_bit;
    logic [tps_pkg::TIME_W-1:0]     end_from_now;
    logic [tps_pkg::TIME_W-1:0]     tns_final;

    assign in_op  = tps_pkg::opcode_t'(s_tuser);
    assign in_ch  = s_tdata[5:0];
    assign in_now = s_tdata[69:6];
    assign in_idx = s_tdata[73:70];
    assign in_len = s_tdata[137:74];

    assign out_free = !out_valid_reg || m_tready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign s_tready = s1_free;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // effective slice count: zero counts as one, saturate at table depth
    always_comb
    begin
        if (num_slices_reg == '0)
            n_eff = tps_pkg::NSL_W'(1);
        else if (num_slices_reg > tps_pkg::NSL_W'(tps_pkg::MAX_SLICES))
            n_eff = tps_pkg::NSL_W'(tps_pkg::MAX_SLICES);
        else
            n_eff = num_slices_reg;
    end

    assign full_ext  = ({{tps_pkg::MAX_SLICES{1'b0}}, 1'b1} << n_eff) -
                       {{tps_pkg::MAX_SLICES{1'b0}}, 1'b1};
    assign full_mask = full_ext[tps_pkg::MAX_SLICES-1:0];
    assign ch_bit    = {{(tps_pkg::MAX_SLICES-1){1'b0}}, 1'b1} <<
                       in_ch[tps_pkg::SLICE_IDX_W-1:0];
    assign pos_inc      = pos_reg + tps_pkg::NSL_W'(1);
    assign end_from_now = in_now + hyper_reg;

    // control update for the word at the input
    always_comb
    begin
        pos_next        = pos_reg;
        running_next    = running_reg;
        mask_next       = mask_reg;
        cycle_end_next  = cycle_end_reg;
        s1_nv_next      = 1'b0;
        s1_ns_next      = '0;
        s1_tv_next      = 1'b0;
        s1_tns_next     = '0;
        s1_use_mem_next = 1'b0;
        s1_st_next      = tps_pkg::ST_HANDLED;
        p_sel           = pos_reg;
        mem_we          = 1'b0;

        if (in_op == tps_pkg::OP_LOAD)
        begin
            mem_we     = (int'(in_idx) < tps_pkg::MAX_SLICES);
            s1_st_next = tps_pkg::ST_LOADED;
        end
        else if (in_ch == timer_ch_reg)
        begin
            s1_use_mem_next = 1'b1;
            if (!running_reg)
            begin
                cycle_end_next = end_from_now;
                running_next   = 1'b1;
            end
            else if (pos_inc >= n_eff)
            begin
                if (in_now < cycle_end_reg)
                begin
                    // pad out the rest of the hyperperiod
                    pos_next        = n_eff;
                    s1_use_mem_next = 1'b0;
                    s1_tv_next      = 1'b1;
                    s1_tns_next     = cycle_end_reg - in_now;
                end
                else
                begin
                    // wrap to the first slice
                    cycle_end_next = end_from_now;
                    pos_next       = '0;
                    p_sel          = '0;
                end
            end
            else
            begin
                pos_next = pos_inc;
                p_sel    = pos_inc;
            end

            if (p_sel >= tps_pkg::NSL_W'(tps_pkg::MAX_SLICES))
                p_sel = '0;
            if (s1_use_mem_next)
            begin
                s1_nv_next = 1'b1;
                s1_ns_next = tps_pkg::NOTIFY_W'(p_sel);
                s1_tv_next = 1'b1;
            end
        end
        else if (in_ch < {1'b0, n_eff})
        begin
            if ((mask_reg & ch_bit) != '0)
                s1_st_next = tps_pkg::ST_ALREADY;
            else
            begin
                mask_next = mask_reg | ch_bit;
                if ((mask_reg | ch_bit) == full_mask)
                begin
                    s1_tv_next  = 1'b1;
                    s1_tns_next = start_delay_reg;
                end
            end
        end
        else
            s1_st_next = tps_pkg::ST_UNKNOWN;
    end

    assign rd_addr   = tps_pkg::SLICE_IDX_W'(p_sel);
    assign wr_addr   = tps_pkg::SLICE_IDX_W'(in_idx);
    assign tns_final = s1_use_mem_reg ? rd_data_reg : s1_tns_reg;

    // slice table: write for loads, registered read for timer words
    always_ff @(posedge clk)
    begin
        if (accept && mem_we)
            slice_mem[wr_addr] <= in_len;
        if (accept)
            rd_data_reg <= slice_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_ch_reg    <= tps_pkg::TIMER_CH_RESET;
            num_slices_reg  <= tps_pkg::NUM_SLICES_RESET;
            hyper_reg       <= '0;
            start_delay_reg <= tps_pkg::START_DELAY_RESET;
            pos_reg         <= '0;
            running_reg     <= 1'b0;
            mask_reg        <= '0;
            cycle_end_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (tps_pkg::cfg_idx_t'(cfg_addr))
                    tps_pkg::CFG_TIMER_CH:    timer_ch_reg    <= cfg_wdata[5:0];
                    tps_pkg::CFG_NUM_SLICES:  num_slices_reg  <= cfg_wdata[4:0];
                    tps_pkg::CFG_HYPERPERIOD: hyper_reg       <= cfg_wdata;
                    tps_pkg::CFG_START_DELAY: start_delay_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (accept)
            begin
                pos_reg       <= pos_next;
                running_reg   <= running_next;
                mask_reg      <= mask_next;
                cycle_end_reg <= cycle_end_next;
            end

            if (s1_free)
                s1_valid_reg <= accept;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_nv_reg      <= s1_nv_next;
            s1_ns_reg      <= s1_ns_next;
            s1_tv_reg      <= s1_tv_next;
            s1_tns_reg     <= s1_tns_next;
            s1_use_mem_reg <= s1_use_mem_next;
            s1_st_reg      <= s1_st_next;
        end
        if (out_free && s1_valid_reg)
            out_data_reg <= {s1_st_reg, tns_final, s1_tv_reg, s1_ns_reg, s1_nv_reg};
    end

    `TPS_ASSERT(a_pos_bounded, clk, rst_n,
        (pos_reg <= tps_pkg::NSL_W'(tps_pkg::MAX_SLICES)),
        "slice position beyond table depth")
    `TPS_ASSERT(a_running_sticks, clk, rst_n,
        !$fell(running_reg),
        "schedule stopped after start")
    `TPS_ASSERT(a_full_blocks, clk, rst_n,
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready,
        "input taken while both stages are stalled")
    `TPS_ASSERT(a_notify_times, clk, rst_n,
        (s1_valid_reg && s1_use_mem_reg) |-> (s1_nv_reg && s1_tv_reg),
        "table read without slice notify")

endmodule

// ===== dv/sched_result_check.sv =====
// ---------------------------------------------------------------------------
// Partition scheduler result checker
// Watches the input, output and register-write channels of the scheduler,
// predicts every result word from its own copy of the slice table, ready
// mask and schedule position, and compares field by field in order.
// ---------------------------------------------------------------------------
module sched_result_check
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [tps_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                             s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [tps_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [tps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [tps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                               mismatches,
    output int                               outstanding
);
    import tps_pkg::*;

    localparam int PRINT_CAP = 200;

    typedef struct {
        logic                notify;
        logic [NOTIFY_W-1:0] notify_slice;
        logic                timeout;
        logic [TIME_W-1:0]   timeout_ns;
        status_t             status;
    } sched_result_t;

    sched_result_t      pending_results[$];

    // scheduler state as the block should hold it
    logic [TIME_W-1:0]  slice_len [MAX_SLICES];
    int                 slot;
    bit                 sched_running;
    logic [31:0]        ready_bits;
    logic [TIME_W-1:0]  frame_end;

    // register copies
    logic [CHAN_W-1:0]  timer_ch;
    logic [NSL_W-1:0]   slice_cnt_reg;
    logic [TIME_W-1:0]  frame_len;
    logic [TIME_W-1:0]  start_delay;

    function automatic sched_result_t next_schedule_result(opcode_t op, logic [CHAN_W-1:0] ch,
        logic [TIME_W-1:0] now, logic [LOAD_IDX_W-1:0] idx, logic [TIME_W-1:0] len);
        sched_result_t r;
        int            n;
        bit            emit;
        logic [31:0]   full_mask;
        r.notify       = 1'b0;
        r.notify_slice = '0;
        r.timeout      = 1'b0;
        r.timeout_ns   = '0;
        r.status       = ST_HANDLED;
        if (slice_cnt_reg == 0)
            n = 1;
        else if (slice_cnt_reg > MAX_SLICES)
            n = MAX_SLICES;
        else
            n = int'(slice_cnt_reg);

        if (op == OP_LOAD)
        begin
            slice_len[idx] = len;
            r.status = ST_LOADED;
        end
        else if (ch == timer_ch)
        begin
            emit = 1'b1;
            if (!sched_running)
            begin
                frame_end     = now + frame_len;
                sched_running = 1'b1;
            end
            else
            begin
                slot++;
                if (slot >= n)
                begin
                    slot = n;
                    // pad out the rest of the frame, or wrap to the first slice
                    if (now < frame_end)
                    begin
                        r.timeout    = 1'b1;
                        r.timeout_ns = frame_end - now;
                        emit         = 1'b0;
                    end
                    else
                    begin
                        frame_end = now + frame_len;
                        slot      = 0;
                    end
                end
            end
            if (emit)
            begin
                r.notify       = 1'b1;
                r.notify_slice = slot[NOTIFY_W-1:0];
                r.timeout      = 1'b1;
                r.timeout_ns   = slice_len[slot];
            end
        end
        else if (ch < n)
        begin
            if (ready_bits[ch])
                r.status = ST_ALREADY;
            else
            begin
                full_mask      = (32'd1 << n) - 32'd1;
                ready_bits[ch] = 1'b1;
                if (ready_bits == full_mask)
                begin
                    r.timeout    = 1'b1;
                    r.timeout_ns = start_delay;
                end
            end
        end
        else
            r.status = ST_UNKNOWN;
        return r;
    endfunction

    function automatic void note_mismatch(string field, logic [OUT_DATA_W-1:0] want,
        logic [OUT_DATA_W-1:0] got);
        mismatches++;
        // keep the log short on a badly broken block
        if (mismatches <= PRINT_CAP)
            $display("%0t: mismatch in %s: expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        if (!rst_n)
        begin
            pending_results.delete();
            for (int i = 0; i < MAX_SLICES; i++)
                slice_len[i] = '0;
            slot          = 0;
            sched_running = 1'b0;
            ready_bits    = '0;
            frame_end     = '0;
            timer_ch      = TIMER_CH_RESET;
            slice_cnt_reg = NUM_SLICES_RESET;
            frame_len     = '0;
            start_delay   = START_DELAY_RESET;
            outstanding  <= 0;
        end
        else
        begin
            // results leave only after the stage 1 and output registers, so check first
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                    note_mismatch("word with nothing expected", '0, m_tdata);
                else
                begin
                    want = pending_results.pop_front();
                    if (m_tdata[0] !== want.notify)
                        note_mismatch("notify_valid", OUT_DATA_W'(want.notify),
                                      OUT_DATA_W'(m_tdata[0]));
                    if (m_tdata[4:1] !== want.notify_slice)
                        note_mismatch("notify_slice", OUT_DATA_W'(want.notify_slice),
                                      OUT_DATA_W'(m_tdata[4:1]));
                    if (m_tdata[5] !== want.timeout)
                        note_mismatch("timeout_valid", OUT_DATA_W'(want.timeout),
                                      OUT_DATA_W'(m_tdata[5]));
                    if (m_tdata[69:6] !== want.timeout_ns)
                        note_mismatch("timeout_ns", OUT_DATA_W'(want.timeout_ns),
                                      OUT_DATA_W'(m_tdata[69:6]));
                    if (m_tdata[71:70] !== want.status)
                        note_mismatch("status", OUT_DATA_W'(want.status),
                                      OUT_DATA_W'(m_tdata[71:70]));
                end
            end

            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_addr))
                    CFG_TIMER_CH:    timer_ch      = cfg_wdata[CHAN_W-1:0];
                    CFG_NUM_SLICES:  slice_cnt_reg = cfg_wdata[NSL_W-1:0];
                    CFG_HYPERPERIOD: frame_len     = cfg_wdata;
                    CFG_START_DELAY: start_delay   = cfg_wdata;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                pending_results.push_back(next_schedule_result(opcode_t'(s_tuser),
                    s_tdata[5:0], s_tdata[69:6], s_tdata[73:70], s_tdata[137:74]));

            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// Partition scheduler testbench
// Drives load and notification words with random gaps and output stalls,
// walks the schedule through start, slice advance, padding and wrap under
// many register settings, and leaves all checking to the result checker.
// ---------------------------------------------------------------------------
module tb;
    import tps_pkg::*;

    localparam int HOLD_CYCLES  = 60;
    localparam int STALL_LIMIT  = 4000;
    localparam int TARGET_WORDS = 1350;
    localparam int DRAIN_CYCLES = 10;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int                     mismatches;
    int                     outstanding;
    int                     words_sent = 0;
    bit                     calm       = 1'b0;
    bit                     hold_req   = 1'b0;
    logic [CHAN_W-1:0]      timer_ch_cur = TIMER_CH_RESET;
    int                     slices_cur   = 1;
    logic [TIME_W-1:0]      timer_now    = '0;

    time_partition_scheduler dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    sched_result_check result_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_word(opcode_t op, logic [CHAN_W-1:0] ch, logic [TIME_W-1:0] now,
        logic [LOAD_IDX_W-1:0] idx, logic [TIME_W-1:0] len);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'b0, len, idx, now, ch};
        do @(posedge clk); while (!s_tready);
        words_sent++;
    endtask

    // stop offering and hold until every result word has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic configure(logic [CHAN_W-1:0] tch, logic [NSL_W-1:0] nsl,
        logic [TIME_W-1:0] period, logic [TIME_W-1:0] delay);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_TIMER_CH;
        cfg_wdata <= {58'd0, tch};
        @(posedge clk);
        cfg_addr  <= CFG_NUM_SLICES;
        cfg_wdata <= {59'd0, nsl};
        @(posedge clk);
        cfg_addr  <= CFG_HYPERPERIOD;
        cfg_wdata <= period;
        @(posedge clk);
        cfg_addr  <= CFG_START_DELAY;
        cfg_wdata <= delay;
        @(posedge clk);
        cfg_we    <= 1'b0;
        timer_ch_cur = tch;
        if (nsl == 0)
            slices_cur = 1;
        else if (nsl > MAX_SLICES)
            slices_cur = MAX_SLICES;
        else
            slices_cur = int'(nsl);
    endtask

    // output side: random stalls, plus one long hold on request
    initial
    begin
        int hold;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold     = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                hold     = pick_gap() + 1;
                m_tready <= 1'b0;
            end
            else
            begin
                hold     = 1;
                m_tready <= 1'b1;
            end
            repeat (hold) @(posedge clk);
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int                phase;
        int                r;
        logic [CHAN_W-1:0] tch;
        logic [NSL_W-1:0]  nsl;
        int                eff;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] delay;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: table extremes, then reset settings (timer 63, one slice)
        send_word(OP_LOAD, 6'd0, '0, 4'd0, '0);
        send_word(OP_LOAD, 6'd63, '1, 4'd15, '1);
        send_word(OP_LOAD, CHAN_W'($urandom_range(0, 63)), rand64(), 4'd1, rand64());
        send_word(OP_LOAD, CHAN_W'($urandom_range(0, 63)), rand64(), 4'd2, rand64());
        send_word(OP_LOAD, CHAN_W'($urandom_range(0, 63)), rand64(), 4'd3, rand64());
        send_word(OP_NOTIFY, 6'd5, rand64(), 4'd0, '0);
        // timer before anyone is ready starts the schedule
        send_word(OP_NOTIFY, 6'd63, '0, 4'd15, '1);
        send_word(OP_NOTIFY, 6'd0, '0, 4'd0, '0);
        send_word(OP_NOTIFY, 6'd0, '1, 4'd15, '1);
        // past the end at the top of time: wrap, then pad twice
        send_word(OP_NOTIFY, 6'd63, '1, 4'd0, '0);
        send_word(OP_NOTIFY, 6'd63, '0, 4'd0, '0);
        send_word(OP_NOTIFY, 6'd63, 64'd1, 4'd0, '0);

        // zero slice count, timer on channel 0 beats the ready meaning
        configure(6'd0, 5'd0, '1, '0);
        send_word(OP_NOTIFY, 6'd0, 64'd5, 4'd0, '0);
        send_word(OP_NOTIFY, 6'd63, 64'd6, 4'd0, '0);

        // timer inside the partition range
        configure(6'd2, 5'd4, 64'd1000, '1);
        send_word(OP_NOTIFY, 6'd1, rand64(), 4'd0, '0);
        send_word(OP_NOTIFY, 6'd3, rand64(), 4'd0, '0);
        timer_now = 64'd100;
        repeat (4)
        begin
            timer_now = timer_now + 64'd300;
            send_word(OP_NOTIFY, 6'd2, timer_now, 4'd0, '0);
        end
        configure(6'd63, 5'd4, 64'd1000, '1);
        send_word(OP_NOTIFY, 6'd2, rand64(), 4'd0, '0);

        // fill the rest of the table before any larger schedule reads it
        for (int i = 4; i < 15; i++)
            send_word(OP_LOAD, CHAN_W'($urandom_range(0, 63)), rand64(), LOAD_IDX_W'(i),
                      rand64());

        phase = 0;
        while (words_sent < TARGET_WORDS)
        begin
            case ($urandom_range(0, 7))
                0:       nsl = 5'd0;
                1:       nsl = 5'd1;
                2:       nsl = 5'd16;
                3:       nsl = NSL_W'($urandom_range(17, 31));
                default: nsl = NSL_W'($urandom_range(2, 15));
            endcase
            eff = (nsl == 0) ? 1 : ((nsl > MAX_SLICES) ? MAX_SLICES : int'(nsl));
            case ($urandom_range(0, 5))
                0:       tch = 6'd0;
                1:       tch = CHAN_W'($urandom_range(0, 63));
                2:       tch = 6'd63;
                default: tch = CHAN_W'($urandom_range(16, 63));
            endcase
            case ($urandom_range(0, 9))
                0:       period = '0;
                1:       period = '1;
                default: period = TIME_W'($urandom_range(0, 450 * (eff + 1)));
            endcase
            case ($urandom_range(0, 5))
                0:       delay = '0;
                1:       delay = '1;
                default: delay = rand64();
            endcase
            configure(tch, nsl, period, delay);
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                timer_now = '1 - TIME_W'($urandom_range(0, 3000));

            if (phase == 1)
            begin
                // long output hold while words keep coming: input must stall
                calm     = 1'b1;
                hold_req = 1'b1;
                repeat (12)
                begin
                    timer_now = timer_now + TIME_W'($urandom_range(0, 600));
                    send_word(OP_NOTIFY, timer_ch_cur, timer_now,
                              LOAD_IDX_W'($urandom_range(0, 15)), rand64());
                end
                calm = 1'b0;
            end

            repeat ($urandom_range(40, 120))
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    timer_now = timer_now + TIME_W'($urandom_range(0, 600));
                    send_word(OP_NOTIFY, timer_ch_cur, timer_now,
                              LOAD_IDX_W'($urandom_range(0, 15)), rand64());
                end
                else if (r < 70)
                    send_word(OP_NOTIFY, CHAN_W'($urandom_range(0, slices_cur - 1)),
                              rand64(), LOAD_IDX_W'($urandom_range(0, 15)), rand64());
                else if (r < 78)
                    send_word(OP_LOAD, CHAN_W'($urandom_range(0, 63)), rand64(),
                              LOAD_IDX_W'($urandom_range(0, 15)), rand64());
                else if (r < 86)
                    send_word(OP_NOTIFY, CHAN_W'($urandom_range(0, 63)), rand64(),
                              LOAD_IDX_W'($urandom_range(0, 15)), rand64());
                else if (r < 92)
                    send_word(OP_NOTIFY, timer_ch_cur, rand64(),
                              LOAD_IDX_W'($urandom_range(0, 15)), rand64());
                else
                    send_word(OP_NOTIFY, CHAN_W'($urandom_range(slices_cur, 63)), rand64(),
                              LOAD_IDX_W'($urandom_range(0, 15)), rand64());
            end
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
